FILE: src/prq_pkg.sv
package prq_pkg;

    // Action codes carried on the input channel.
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_PICK = 2'd1;
    localparam logic [1:0] ACT_POLL = 2'd2;

    // Width of the action field.
    localparam int ACTION_BITS = 2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SHIFT,
        ST_PLACE
    } prq_state_t;

    // Result control from the sequencer to the output register.
    typedef struct packed {
        logic load;
        logic valid_res;
        logic full_drop;
    } prq_res_t;

endpackage

FILE: src/prq_ram.sv
module prq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/prq_seq.sv
module prq_seq #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int ID_BITS       = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [prq_pkg::ACTION_BITS-1:0]        in_action,
    input  logic [ID_BITS-1:0]                     in_id,
    input  logic [PRIORITY_BITS-1:0]               in_prio,
    input  logic                                   out_free,
    output prq_pkg::prq_res_t                      res,
    output logic [ID_BITS-1:0]                     res_id,
    output logic [PRIORITY_BITS-1:0]               res_prio,
    output logic                                   ram_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_wr_addr,
    output logic [ID_BITS+PRIORITY_BITS-1:0]       ram_wr_data,
    output logic                                   ram_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_rd_addr,
    input  logic [ID_BITS+PRIORITY_BITS-1:0]       ram_rd_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    prq_pkg::prq_state_t state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            occ_reg, occ_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic [ID_BITS-1:0]       new_id_reg, new_id_next;
    logic [PRIORITY_BITS-1:0] new_prio_reg, new_prio_next;
    logic                     poll_reg, poll_next;

    logic                     in_fire;
    logic [CW-1:0]            occ_m1;
    logic [AW-1:0]            idx_m1;
    logic [AW-1:0]            idx_m2;
    logic [ID_BITS-1:0]       rd_id;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     shift_on;

    // Maps a position counted from the head onto a memory address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign in_ready = (state_reg == prq_pkg::ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign occ_m1   = occ_reg - CW'(1);
    assign idx_m1   = idx_reg - AW'(1);
    assign idx_m2   = idx_reg - AW'(2);
    assign rd_id    = ram_rd_data[ID_BITS-1:0];
    assign rd_prio  = ram_rd_data[ID_BITS+PRIORITY_BITS-1:ID_BITS];
    // The entry read last moves one place toward the tail when its priority is not above the new one.
    assign shift_on = (rd_prio <= new_prio_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_action)
                        prq_pkg::ACT_PUSH:
                        begin
                            if ((occ_reg != DEPTH_C) && (occ_reg != '0))
                            begin
                                state_next = prq_pkg::ST_SHIFT;
                            end
                        end
                        prq_pkg::ACT_PICK, prq_pkg::ACT_POLL:
                        begin
                            if (occ_reg != '0)
                            begin
                                state_next = prq_pkg::ST_HEAD;
                            end
                        end
                        default:
                        begin
                            state_next = prq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            prq_pkg::ST_HEAD:
            begin
                state_next = prq_pkg::ST_IDLE;
            end
            prq_pkg::ST_SHIFT:
            begin
                if (!shift_on)
                begin
                    state_next = prq_pkg::ST_IDLE;
                end
                else if (idx_reg == AW'(1))
                begin
                    state_next = prq_pkg::ST_PLACE;
                end
            end
            prq_pkg::ST_PLACE:
            begin
                state_next = prq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = prq_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory accesses, results and bookkeeping.
    always_comb
    begin
        head_next     = head_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        new_id_next   = new_id_reg;
        new_prio_next = new_prio_reg;
        poll_next     = poll_reg;
        res           = '0;
        res_id        = '0;
        res_prio      = '0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = '0;
        ram_wr_data   = {new_prio_reg, new_id_reg};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        unique case (state_reg)
            prq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res.load = 1'b1;
                    unique case (in_action)
                        prq_pkg::ACT_PUSH:
                        begin
                            if (occ_reg == DEPTH_C)
                            begin
                                res.full_drop = 1'b1;
                            end
                            else
                            begin
                                res.valid_res = 1'b1;
                                new_id_next   = in_id;
                                new_prio_next = in_prio;
                                if (occ_reg == '0)
                                begin
                                    // An empty queue takes the task straight at the head.
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = head_reg;
                                    ram_wr_data = {in_prio, in_id};
                                    occ_next    = occ_reg + CW'(1);
                                end
                                else
                                begin
                                    // Start the scan at the tail entry.
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = phys(head_reg, occ_m1[AW-1:0]);
                                    idx_next    = occ_reg[AW-1:0];
                                end
                            end
                        end
                        prq_pkg::ACT_PICK, prq_pkg::ACT_POLL:
                        begin
                            if (occ_reg != '0)
                            begin
                                // The result waits for the head entry to come back.
                                res.load    = 1'b0;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = head_reg;
                                poll_next   = (in_action == prq_pkg::ACT_POLL);
                            end
                        end
                        default:
                        begin
                            res.load = 1'b1;
                        end
                    endcase
                end
            end
            prq_pkg::ST_HEAD:
            begin
                res.load      = 1'b1;
                res.valid_res = 1'b1;
                res_id        = rd_id;
                res_prio      = rd_prio;
                if (poll_reg)
                begin
                    head_next = phys(head_reg, AW'(1));
                    occ_next  = occ_m1;
                end
            end
            prq_pkg::ST_SHIFT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_reg, idx_reg);
                if (shift_on)
                begin
                    // Move the entry down and fetch the one ahead of it.
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_m1;
                    if (idx_reg != AW'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = phys(head_reg, idx_m2);
                    end
                end
                else
                begin
                    occ_next = occ_reg + CW'(1);
                end
            end
            prq_pkg::ST_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_reg, idx_reg);
                occ_next    = occ_reg + CW'(1);
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prq_pkg::ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        new_id_reg   <= new_id_next;
        new_prio_reg <= new_prio_next;
        poll_reg     <= poll_next;
    end

endmodule

FILE: src/priority_ready_queue_core.sv
// Ready queue of task ids held in descending order of priority.
// Input channel s_*: s_tuser carries the action (push, pick, poll) and
// s_tdata carries the task id and its priority. Output channel m_*: one
// result for every request, with the head id and priority in m_tdata and
// the valid and full-drop flags in m_tuser.
// A push goes in ahead of the first stored entry whose priority is less
// than or equal to its own; a push into a full queue is dropped and flagged.
// A pick reports the head, a poll reports and removes it.
// Entries live in one RAM used as a ring, with a head pointer and a count.
// Results: a push result and every empty, full or unused-code result is
// registered in the cycle after the request; a pick or poll reads the
// head entry from the RAM first and loads its result in ST_HEAD. The block
// takes no new request in ST_HEAD, nor while a push scans from the tail in
// ST_SHIFT (and ST_PLACE when it lands at the head); the scan does one RAM
// read and one write per cycle. A push onto an empty queue needs no scan.
// Reset empties the queue at once; the RAM contents need no clearing.
// A result waits in the output register while m_tready is low, and a new
// request is taken only once the register is free or being emptied.
module priority_ready_queue_core #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int ID_BITS       = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: task_id, priority_req, zero fill.
    input  logic [((ID_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: action.
    input  logic [prq_pkg::ACTION_BITS-1:0]           s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // Fields from bit 0: head_id, head_priority, zero fill.
    output logic [((ID_BITS+PRIORITY_BITS+7)/8)*8-1:0] m_tdata,
    // Fields from bit 0: valid_res, full_drop.
    output logic [1:0]                                m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = ID_BITS + PRIORITY_BITS;
    localparam int DW = ((EW + 7) / 8) * 8;

    prq_pkg::prq_res_t        res;
    logic [ID_BITS-1:0]       res_id;
    logic [PRIORITY_BITS-1:0] res_prio;
    logic                     out_free;

    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [EW-1:0]            ram_wr_data;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [EW-1:0]            ram_rd_data;

    logic                     m_tvalid_reg;
    logic [EW-1:0]            m_data_reg;
    logic [1:0]               m_flags_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    prq_seq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .ID_BITS       (ID_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_id       (s_tdata[ID_BITS-1:0]),
        .in_prio     (s_tdata[EW-1:ID_BITS]),
        .out_free    (out_free),
        .res         (res),
        .res_id      (res_id),
        .res_prio    (res_prio),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    prq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            m_data_reg  <= {res_prio, res_id};
            m_flags_reg <= {res.full_drop, res.valid_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(m_data_reg);
    assign m_tuser  = m_flags_reg;

    // A result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> out_free)
    else $error("result loaded while output register is occupied");

    // A result is loaded in the cycle of its request or in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> ((s_tvalid && s_tready) || $past(s_tvalid && s_tready)))
    else $error("result loaded without a recent request");

    // A result is never both accepted and dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> !(res.valid_res && res.full_drop))
    else $error("result flagged both valid and dropped");

endmodule

FILE: verif/priority_ready_queue_core_tb.sv
module priority_ready_queue_core_tb;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int ID_BITS       = 16;
    localparam int DATA_BITS     = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8;

    // The fourth action code has no meaning and must be ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles to let pass once the last result is in, so that a push scan can end.
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

    // One result as the block should report it.
    typedef struct packed {
        logic                     valid_res;
        logic [ID_BITS-1:0]       head_id;
        logic [PRIORITY_BITS-1:0] head_priority;
        logic                     full_drop;
    } queue_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_BITS-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // Shadow copy of the queue, head in cell 0.
    logic [ID_BITS-1:0]       shadow_ids [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] shadow_prios [QUEUE_DEPTH];
    int                       shadow_count;

    queue_result_t pending_results[$];

    bit idle_enable;
    int stall_left;
    int error_count;
    int requests_sent;
    int results_checked;
    int drops_predicted;
    int empty_reads_predicted;
    int pops_predicted;

    priority_ready_queue_core #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PRIORITY_BITS(PRIORITY_BITS),
        .ID_BITS      (ID_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // Apply one accepted request to the shadow queue and return its result.
    function automatic queue_result_t apply_request(input logic [1:0] action,
                                                    input logic [ID_BITS-1:0] id,
                                                    input logic [PRIORITY_BITS-1:0] prio);
        queue_result_t res;
        int            pos;
        int            k;
        res = '0;
        case (action)
            prq_pkg::ACT_PUSH:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                begin
                    res.full_drop = 1'b1;
                    drops_predicted++;
                end
                else
                begin
                    // New entry goes ahead of the first one that is not higher.
                    pos = 0;
                    while (pos < shadow_count && shadow_prios[pos] > prio)
                        pos++;
                    for (k = shadow_count; k > pos; k--)
                    begin
                        shadow_ids[k]   = shadow_ids[k-1];
                        shadow_prios[k] = shadow_prios[k-1];
                    end
                    shadow_ids[pos]   = id;
                    shadow_prios[pos] = prio;
                    shadow_count++;
                    res.valid_res = 1'b1;
                end
            end
            prq_pkg::ACT_PICK, prq_pkg::ACT_POLL:
            begin
                if (shadow_count == 0)
                    empty_reads_predicted++;
                else
                begin
                    res.valid_res     = 1'b1;
                    res.head_id       = shadow_ids[0];
                    res.head_priority = shadow_prios[0];
                    if (action == prq_pkg::ACT_POLL)
                    begin
                        for (k = 1; k < shadow_count; k++)
                        begin
                            shadow_ids[k-1]   = shadow_ids[k];
                            shadow_prios[k-1] = shadow_prios[k];
                        end
                        shadow_count--;
                        pops_predicted++;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        if (error_count < 100)
            $display("MISMATCH %s on result %0d: expected 0x%0h, got 0x%0h",
                     field, results_checked, want, got);
        error_count++;
    endtask

    // Send one request, with an optional random gap ahead of it.
    task automatic send_request(input logic [1:0] action,
                                input logic [ID_BITS-1:0] id,
                                input logic [PRIORITY_BITS-1:0] prio);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {prio, id};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_request(action, id, prio));
        requests_sent++;
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Priorities drawn from a few shapes, narrow ones to force ties.
    function automatic logic [PRIORITY_BITS-1:0] pick_priority(input int shape);
        case (shape)
            0: return PRIORITY_BITS'($urandom_range(0, 3));
            1: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            2: return PRIORITY_BITS'($urandom_range(120, 135));
            default: return PRIORITY_BITS'($urandom);
        endcase
    endfunction

    // Empty reads, the unused code, extremes of the fields and ties.
    task automatic test_edge_cases();
        send_request(prq_pkg::ACT_POLL, '0, '0);
        send_request(prq_pkg::ACT_PICK, '1, '1);
        send_request(ACT_UNUSED, '1, '1);
        send_request(prq_pkg::ACT_PUSH, '0, '0);
        send_request(prq_pkg::ACT_PUSH, '1, '1);
        send_request(prq_pkg::ACT_PUSH, 16'h1234, 8'h80);
        send_request(prq_pkg::ACT_PUSH, 16'h5678, 8'h80);
        send_request(prq_pkg::ACT_PUSH, 16'h00ff, 8'h00);
        send_request(ACT_UNUSED, 16'ha5a5, 8'h5a);
        send_request(prq_pkg::ACT_PICK, '0, '0);
        repeat (5) send_request(prq_pkg::ACT_POLL, '0, '0);
        send_request(prq_pkg::ACT_POLL, '0, '0);
        send_request(prq_pkg::ACT_PICK, '0, '0);
        send_request(ACT_UNUSED, '0, '0);
    endtask

    // Fill the queue, push into it while full, then empty it.
    task automatic test_full_queue();
        repeat (QUEUE_DEPTH)
            send_request(prq_pkg::ACT_PUSH, ID_BITS'($urandom),
                         PRIORITY_BITS'($urandom_range(0, 7)));
        pause_until_drained();
        send_request(prq_pkg::ACT_PUSH, '1, '1);
        send_request(prq_pkg::ACT_PUSH, '0, '0);
        send_request(ACT_UNUSED, '1, '1);
        send_request(prq_pkg::ACT_PICK, '0, '0);
        repeat (QUEUE_DEPTH) send_request(prq_pkg::ACT_POLL, '0, '0);
        send_request(prq_pkg::ACT_POLL, '0, '0);
    endtask

    // Random mix, with the share of pushes changing from phase to phase so
    // that the fill level sweeps between empty and full.
    task automatic run_random_phase(input int count, input int push_pct);
        int          shape;
        int          roll;
        logic [1:0]  action;
        shape = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                action = ACT_UNUSED;
            else if (roll < 2 + push_pct)
                action = prq_pkg::ACT_PUSH;
            else if ($urandom_range(0, 9) < 7)
                action = prq_pkg::ACT_POLL;
            else
                action = prq_pkg::ACT_PICK;
            send_request(action, ID_BITS'($urandom), pick_priority(shape));
        end
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 13; phase++)
            run_random_phase(100, $urandom_range(20, 80));
    endtask

    // Requests back to back with the result side always ready.
    task automatic test_back_to_back();
        idle_enable = 1'b0;
        run_random_phase(60, 75);
        run_random_phase(60, 35);
    endtask

    // Result side: random stall bursts that hold m_tready low.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 0, 32'({m_tuser, m_tdata}));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.valid_res)
                    report_mismatch("valid_res", 32'(want.valid_res), 32'(m_tuser[0]));
                if (m_tdata[ID_BITS-1:0] !== want.head_id)
                    report_mismatch("head_id", 32'(want.head_id),
                                    32'(m_tdata[ID_BITS-1:0]));
                if (m_tdata[ID_BITS +: PRIORITY_BITS] !== want.head_priority)
                    report_mismatch("head_priority", 32'(want.head_priority),
                                    32'(m_tdata[ID_BITS +: PRIORITY_BITS]));
                if (m_tuser[1] !== want.full_drop)
                    report_mismatch("full_drop", 32'(want.full_drop), 32'(m_tuser[1]));
            end
            results_checked++;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = prq_pkg::ACT_PUSH;
        m_tready     = 1'b0;
        idle_enable  = 1'b1;
        stall_left   = 0;
        shadow_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_full_queue();
        test_random_mix();
        test_back_to_back();

        // Let the last results come out and the block settle.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d results under random stalls.",
                 requests_sent, results_checked);
        $display("Covered %0d removals, %0d reads of an empty queue, %0d full drops.",
                 pops_predicted, empty_reads_predicted, drops_predicted);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: priority_ready_queue_core.f
src/prq_pkg.sv
src/prq_ram.sv
src/prq_seq.sv
src/priority_ready_queue_core.sv
verif/priority_ready_queue_core_tb.sv
